FILE: rtl/doat_pkg.sv
package doat_pkg;

    // fixed field widths
    localparam int PORT_DOORS = 8;
    localparam int TICK_W     = 32;
    localparam int REPEAT_W   = 16;
    localparam int DELAY_W    = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;

    // parameter defaults
    localparam int DEF_DOORS              = 8;
    localparam int DEF_TICKS_PER_SECOND   = 10000;
    localparam int DEF_DELAY_UNIT_SECONDS = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_DOORS   = 3'd0,
        CFG_DISARMED_MASK  = 3'd1,
        CFG_LAMP_DELAYS    = 3'd2,
        CFG_CENTRAL_DELAYS = 3'd3
    } cfg_idx_t;

    // per-door control for one tick
    typedef struct packed {
        logic step;      // tick accepted, commit state
        logic enable;    // door within the active count
        logic armed;     // sensor is applied
        logic sensor;    // sensor bit, 1 = open
        logic blocked;   // central reporting blocked
    } lane_ctrl_t;

    typedef struct packed {
        logic lamp;
        logic central;
    } lane_res_t;

endpackage

FILE: rtl/doat_lane.sv
module doat_lane #(
    parameter int TICKS_PER_SECOND   = doat_pkg::DEF_TICKS_PER_SECOND,
    parameter int DELAY_UNIT_SECONDS = doat_pkg::DEF_DELAY_UNIT_SECONDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  doat_pkg::lane_ctrl_t            ctrl,
    input  logic [doat_pkg::TICK_W-1:0]     tick_next,
    input  logic [doat_pkg::DELAY_W-1:0]    lamp_delay,
    input  logic [doat_pkg::DELAY_W-1:0]    central_delay,
    output doat_pkg::lane_res_t             res
);

    localparam logic [doat_pkg::TICK_W-1:0] UNIT_TICKS =
        doat_pkg::TICK_W'(DELAY_UNIT_SECONDS * TICKS_PER_SECOND);
    localparam logic [doat_pkg::TICK_W-1:0] SECOND_TICKS =
        doat_pkg::TICK_W'(TICKS_PER_SECOND);
    localparam logic [doat_pkg::REPEAT_W-1:0] REPEAT_MAX = '1;

    logic                            flag_reg,   flag_next;
    logic [doat_pkg::TICK_W-1:0]     start_reg,  start_next;
    logic [doat_pkg::REPEAT_W-1:0]   repeat_reg, repeat_next;
    // seconds-per-repeat offset kept alongside the count, avoids a multiply
    logic [doat_pkg::TICK_W-1:0]     offset_reg, offset_next;

    logic                            update;
    logic [doat_pkg::REPEAT_W-1:0]   repeat_cur;
    logic [doat_pkg::TICK_W-1:0]     offset_cur;
    logic [doat_pkg::TICK_W-1:0]     lamp_limit;
    logic [doat_pkg::TICK_W-1:0]     central_limit;
    logic                            lamp_hit;
    logic                            central_hit;

    always_comb begin
        update     = ctrl.enable & ctrl.armed;
        flag_next  = update ? ctrl.sensor : flag_reg;
        start_next = (update & ctrl.sensor & ~flag_reg) ? tick_next : start_reg;
        repeat_cur = (update & ~ctrl.sensor) ? '0 : repeat_reg;
        offset_cur = (update & ~ctrl.sensor) ? '0 : offset_reg;

        lamp_limit    = start_next + doat_pkg::TICK_W'(lamp_delay) * UNIT_TICKS;
        central_limit = start_next + doat_pkg::TICK_W'(central_delay) * UNIT_TICKS
                        + offset_cur;

        lamp_hit    = ctrl.enable & flag_next & (tick_next > lamp_limit);
        central_hit = ctrl.enable & flag_next & ~ctrl.blocked
                      & (tick_next > central_limit);

        repeat_next = repeat_cur;
        offset_next = offset_cur;
        if (central_hit && repeat_cur != REPEAT_MAX) begin
            repeat_next = repeat_cur + 1'b1;
            offset_next = offset_cur + SECOND_TICKS;
        end

        res.lamp    = lamp_hit;
        res.central = central_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= 1'b0;
            repeat_reg <= '0;
            offset_reg <= '0;
        end else if (ctrl.step) begin
            flag_reg   <= flag_next;
            repeat_reg <= repeat_next;
            offset_reg <= offset_next;
        end
    end

    // start tick is only read while the flag is set, which implies a write
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            start_reg <= start_next;
        end
    end

endmodule

FILE: rtl/doat_merge.sv
module doat_merge #(
    parameter int DOORS = doat_pkg::DEF_DOORS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  doat_pkg::lane_res_t [DOORS-1:0]      lane_res,
    input  logic                                 m_ready,
    output logic                                 out_free,
    output logic                                 m_valid,
    output logic [doat_pkg::PORT_DOORS-1:0]      m_lamp_on,
    output logic [doat_pkg::PORT_DOORS-1:0]      m_central_alarm,
    output logic                                 m_sound
);

    logic                                valid_reg;
    logic [doat_pkg::PORT_DOORS-1:0]     lamp_reg,    lamp_next;
    logic [doat_pkg::PORT_DOORS-1:0]     central_reg, central_next;
    logic                                sound_reg;

    always_comb begin
        lamp_next    = '0;
        central_next = '0;
        for (int n = 0; n < DOORS; n++) begin
            lamp_next[n]    = lane_res[n].lamp;
            central_next[n] = lane_res[n].central;
        end
    end

    assign out_free = ~valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lamp_reg    <= lamp_next;
            central_reg <= central_next;
            sound_reg   <= |lamp_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_lamp_on       = lamp_reg;
    assign m_central_alarm = central_reg;
    assign m_sound         = sound_reg;

endmodule

FILE: rtl/door_open_alarm_timer_unit.sv
// channel  | direction | beat contents
// ---------+-----------+------------------------------------------------
// s_       | in        | s_door_open[7:0], s_central_blocked
// m_       | out       | m_lamp_on[7:0], m_central_alarm[7:0], m_sound
// cfg_     | in        | cfg_index[2:0], cfg_data[63:0]
//
// one tick beat per cycle while s_ready is high; the result beat shows the cycle after
// result path: per-door lanes do the limit add and compare, then the output register
// aresetn (synchronous) clears the tick count, door flags, repeat counts and registers
// a new tick is taken whenever the output register is empty or is being drained
// a stall on m_ready holds s_ready low only while a result waits
module door_open_alarm_timer_unit #(
    parameter int DOORS              = doat_pkg::DEF_DOORS,
    parameter int TICKS_PER_SECOND   = doat_pkg::DEF_TICKS_PER_SECOND,
    parameter int DELAY_UNIT_SECONDS = doat_pkg::DEF_DELAY_UNIT_SECONDS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tick channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [doat_pkg::PORT_DOORS-1:0]      s_door_open,
    input  logic                                 s_central_blocked,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [doat_pkg::PORT_DOORS-1:0]      m_lamp_on,
    output logic [doat_pkg::PORT_DOORS-1:0]      m_central_alarm,
    output logic                                 m_sound,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [doat_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [doat_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [doat_pkg::COUNT_W-1:0]        active_doors_reg;
    logic [doat_pkg::PORT_DOORS-1:0]     disarmed_mask_reg;
    logic [doat_pkg::CFG_DATA_W-1:0]     lamp_delays_reg;
    logic [doat_pkg::CFG_DATA_W-1:0]     central_delays_reg;

    // time base
    logic [doat_pkg::TICK_W-1:0]         tick_reg, tick_next;

    logic                                step;
    logic                                out_free;
    doat_pkg::lane_ctrl_t [DOORS-1:0]    lane_ctrl;
    doat_pkg::lane_res_t  [DOORS-1:0]    lane_res;

    assign cfg_ready = 1'b1;
    assign s_ready   = out_free;
    assign step      = s_valid & out_free;

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_doors_reg   <= '0;
            disarmed_mask_reg  <= '0;
            lamp_delays_reg    <= '0;
            central_delays_reg <= '0;
        end else if (cfg_valid) begin
            case (doat_pkg::cfg_idx_t'(cfg_index))
                doat_pkg::CFG_ACTIVE_DOORS:   active_doors_reg   <= cfg_data[doat_pkg::COUNT_W-1:0];
                doat_pkg::CFG_DISARMED_MASK:  disarmed_mask_reg  <= cfg_data[doat_pkg::PORT_DOORS-1:0];
                doat_pkg::CFG_LAMP_DELAYS:    lamp_delays_reg    <= cfg_data;
                doat_pkg::CFG_CENTRAL_DELAYS: central_delays_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the tick advances before the sensors are judged, so lanes see the new value
    assign tick_next = tick_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else if (step) begin
            tick_reg <= tick_next;
        end
    end

    // one lane per door; an active count above the lane count simply enables all
    for (genvar n = 0; n < DOORS; n++) begin : g_lane
        always_comb begin
            lane_ctrl[n].step    = step;
            lane_ctrl[n].enable  = doat_pkg::COUNT_W'(n) < active_doors_reg;
            lane_ctrl[n].armed   = ~disarmed_mask_reg[n];
            lane_ctrl[n].sensor  = s_door_open[n];
            lane_ctrl[n].blocked = s_central_blocked;
        end

        doat_lane #(
            .TICKS_PER_SECOND   (TICKS_PER_SECOND),
            .DELAY_UNIT_SECONDS (DELAY_UNIT_SECONDS)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (lane_ctrl[n]),
            .tick_next     (tick_next),
            .lamp_delay    (lamp_delays_reg[doat_pkg::DELAY_W*n +: doat_pkg::DELAY_W]),
            .central_delay (central_delays_reg[doat_pkg::DELAY_W*n +: doat_pkg::DELAY_W]),
            .res           (lane_res[n])
        );
    end

    // gather lane bits, sound and the output register
    doat_merge #(
        .DOORS (DOORS)
    ) u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (step),
        .lane_res        (lane_res),
        .m_ready         (m_ready),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_lamp_on       (m_lamp_on),
        .m_central_alarm (m_central_alarm),
        .m_sound         (m_sound)
    );

endmodule

FILE: rtl/doat_checker.sv
module doat_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_central_blocked,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [doat_pkg::PORT_DOORS-1:0]   m_lamp_on,
    input logic [doat_pkg::PORT_DOORS-1:0]   m_central_alarm,
    input logic                              m_sound
);

    // every accepted tick beat yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("tick beat accepted without a result beat");

    // a blocked tick never reports a central alarm
    a_blocked_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_central_blocked |=> m_central_alarm == '0)
        else $error("central alarm on a blocked tick");

    // sound follows the lamp bits
    a_sound_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sound == (m_lamp_on != '0))
        else $error("sound does not match lamp bits");

    // the input side is never held off while no result waits
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("tick channel stalled with empty output");

    // a waiting result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lamp_on) && $stable(m_central_alarm))
        else $error("result beat changed while stalled");

endmodule

bind door_open_alarm_timer_unit doat_checker u_doat_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_central_blocked (s_central_blocked),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_lamp_on         (m_lamp_on),
    .m_central_alarm   (m_central_alarm),
    .m_sound           (m_sound)
);

FILE: bench/tb_door_open_alarm_timer_unit.sv
module tb_door_open_alarm_timer_unit;

    // timing of the time base as built into the block (default parameters)
    localparam longint TICKS_PER_S    = doat_pkg::DEF_TICKS_PER_SECOND;
    localparam longint TICKS_PER_UNIT = doat_pkg::DEF_DELAY_UNIT_SECONDS
                                        * doat_pkg::DEF_TICKS_PER_SECOND;
    localparam int     DOOR_LANES     = doat_pkg::DEF_DOORS;
    localparam int     REPEAT_FULL    = 16'hFFFF;

    // register index with no register behind it, the block must drop the write
    localparam logic [doat_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // long receiver stall used to back the block up
    localparam int STALL_CYCLES  = 60;
    localparam int SEGMENT_TICKS = 45;
    localparam int SEGMENTS      = 8;
    // a held door sees its lamp and first central alarm, then waits on the repeat
    localparam int SOAK_TICKS    = 200;

    typedef struct packed {
        logic [doat_pkg::PORT_DOORS-1:0] lamp;
        logic [doat_pkg::PORT_DOORS-1:0] central;
        logic                            sound;
    } door_report_t;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    // one line of the directed part: a tick beat or a register write
    // for a tick, value[7:0] is the sensor byte and value[8] the central block bit
    typedef struct {
        row_kind_t                        kind;
        logic [doat_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [63:0]                      value;
        bit                               pinned;
        door_report_t                     report;
    } bench_row_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                             s_valid;
    logic                             s_ready;
    logic [doat_pkg::PORT_DOORS-1:0]  s_door_open;
    logic                             s_central_blocked;

    logic                             m_valid;
    logic                             m_ready;
    logic [doat_pkg::PORT_DOORS-1:0]  m_lamp_on;
    logic [doat_pkg::PORT_DOORS-1:0]  m_central_alarm;
    logic                             m_sound;

    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [doat_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [doat_pkg::CFG_DATA_W-1:0]  cfg_data;

    door_open_alarm_timer_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_door_open       (s_door_open),
        .s_central_blocked (s_central_blocked),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lamp_on         (m_lamp_on),
        .m_central_alarm   (m_central_alarm),
        .m_sound           (m_sound),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: registers and per-door timing state
    // ------------------------------------------------------------------
    logic [doat_pkg::COUNT_W-1:0]    shadow_active;
    logic [doat_pkg::PORT_DOORS-1:0] shadow_disarmed;
    logic [63:0]                     shadow_lamp_delays;
    logic [63:0]                     shadow_central_delays;

    logic [doat_pkg::TICK_W-1:0]     door_tick;
    logic                            door_flag    [doat_pkg::PORT_DOORS];
    logic [doat_pkg::TICK_W-1:0]     door_start   [doat_pkg::PORT_DOORS];
    logic [doat_pkg::REPEAT_W-1:0]   door_repeats [doat_pkg::PORT_DOORS];

    door_report_t awaited_reports [$];
    int           mismatches = 0;

    // pinned expectation for the next tick beat, set by the directed walker
    bit           pin_next = 1'b0;
    door_report_t pin_report = '0;

    // idle rates in percent, and the receiver's long stall
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_cycles       = 0;

    function automatic void clear_door_state();
        shadow_active         = '0;
        shadow_disarmed       = '0;
        shadow_lamp_delays    = '0;
        shadow_central_delays = '0;
        door_tick             = '0;
        for (int n = 0; n < doat_pkg::PORT_DOORS; n++) begin
            door_flag[n]    = 1'b0;
            door_start[n]   = '0;
            door_repeats[n] = '0;
        end
    endfunction

    function automatic void apply_register(input logic [doat_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [doat_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            doat_pkg::CFG_ACTIVE_DOORS:   shadow_active   = data[doat_pkg::COUNT_W-1:0];
            doat_pkg::CFG_DISARMED_MASK:  shadow_disarmed = data[doat_pkg::PORT_DOORS-1:0];
            doat_pkg::CFG_LAMP_DELAYS:    shadow_lamp_delays    = data;
            doat_pkg::CFG_CENTRAL_DELAYS: shadow_central_delays = data;
            default: ;
        endcase
    endfunction

    // moment after which a door's condition holds, wrapping on 32 bits
    function automatic logic [doat_pkg::TICK_W-1:0] door_deadline(
            input logic [doat_pkg::TICK_W-1:0]   start,
            input logic [doat_pkg::DELAY_W-1:0]  units,
            input logic [doat_pkg::REPEAT_W-1:0] extra_s);
        logic [63:0] sum;
        sum = 64'(start) + 64'(units) * 64'(TICKS_PER_UNIT) + 64'(extra_s) * 64'(TICKS_PER_S);
        return sum[doat_pkg::TICK_W-1:0];
    endfunction

    // one time-base tick: sensors first, then lamps and central alarms on the new tick
    function automatic door_report_t advance_door_timers(
            input logic [doat_pkg::PORT_DOORS-1:0] sensors,
            input logic                            blocked);
        door_report_t rep;
        int           lanes;
        rep   = '0;
        lanes = (shadow_active > DOOR_LANES) ? DOOR_LANES : int'(shadow_active);
        door_tick = door_tick + 1'b1;
        for (int n = 0; n < lanes; n++) begin
            if (!shadow_disarmed[n]) begin
                if (!sensors[n]) begin
                    door_flag[n]    = 1'b0;
                    door_repeats[n] = '0;
                end else begin
                    if (!door_flag[n])
                        door_start[n] = door_tick;
                    door_flag[n] = 1'b1;
                end
            end
        end
        for (int n = 0; n < lanes; n++) begin
            if (door_flag[n]) begin
                if (door_tick > door_deadline(door_start[n], shadow_lamp_delays[8*n +: 8], '0))
                    rep.lamp[n] = 1'b1;
                if (!blocked && door_tick > door_deadline(door_start[n],
                        shadow_central_delays[8*n +: 8], door_repeats[n])) begin
                    rep.central[n] = 1'b1;
                    // repeat count sticks at its top value
                    if (door_repeats[n] != REPEAT_FULL)
                        door_repeats[n] = door_repeats[n] + 1'b1;
                end
            end
        end
        rep.sound = |rep.lamp;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // watch all three channels at the rising edge
    // ------------------------------------------------------------------
    door_report_t seen_report;
    door_report_t due_report;
    door_report_t shadow_report;

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_door_state();
        end else begin
            // result beat goes against the oldest waiting expectation
            if (m_valid && m_ready) begin
                seen_report = '{m_lamp_on, m_central_alarm, m_sound};
                if (awaited_reports.size() == 0) begin
                    $error("result beat with nothing expected: lamp_on %h central_alarm %h %s %b",
                           m_lamp_on, m_central_alarm, "sound", m_sound);
                    mismatches++;
                end else begin
                    due_report = awaited_reports.pop_front();
                    if (seen_report.lamp !== due_report.lamp) begin
                        $error("lamp_on: expected %h, got %h", due_report.lamp, seen_report.lamp);
                        mismatches++;
                    end
                    if (seen_report.central !== due_report.central) begin
                        $error("central_alarm: expected %h, got %h",
                               due_report.central, seen_report.central);
                        mismatches++;
                    end
                    if (seen_report.sound !== due_report.sound) begin
                        $error("sound: expected %b, got %b", due_report.sound, seen_report.sound);
                        mismatches++;
                    end
                end
            end
            // tick beat: state always moves on, pinned rows override the prediction
            if (s_valid && s_ready) begin
                shadow_report = advance_door_timers(s_door_open, s_central_blocked);
                awaited_reports.push_back(pin_next ? pin_report : shadow_report);
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure, or a long stall when asked for
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one tick beat and hold it until taken; valid is left high afterwards
    task automatic send_tick(input logic [doat_pkg::PORT_DOORS-1:0] doors, input logic blocked,
                             input bit pin = 1'b0, input door_report_t pinned = '0);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pin_next          = pin;
        pin_report        = pinned;
        s_valid           <= 1'b1;
        s_door_open       <= doors;
        s_central_blocked <= blocked;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_ticks();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // hold until every expected result beat has come back
    task automatic drain();
        while (awaited_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [doat_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [doat_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // new register set between segments: mostly all doors, short delays
    task automatic shuffle_registers();
        logic [63:0] lamps;
        logic [63:0] centrals;
        lamps    = '0;
        centrals = '0;
        for (int n = 0; n < doat_pkg::PORT_DOORS; n++) begin
            if ($urandom_range(9) == 0) lamps[8*n +: 8] = $urandom_range(255);
            if ($urandom_range(9) == 0) centrals[8*n +: 8] = $urandom_range(255);
        end
        if ($urandom_range(15) == 0) lamps = '1;
        if ($urandom_range(15) == 0) centrals = '1;
        write_reg(doat_pkg::CFG_ACTIVE_DOORS, ($urandom_range(9) < 5) ? 64'(DOOR_LANES)
                                                                      : 64'($urandom_range(15)));
        write_reg(doat_pkg::CFG_DISARMED_MASK,
                  ($urandom_range(2) == 0) ? 64'($urandom_range(255)) : '0);
        write_reg(doat_pkg::CFG_LAMP_DELAYS, lamps);
        write_reg(doat_pkg::CFG_CENTRAL_DELAYS, centrals);
        if ($urandom_range(7) == 0)
            write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    endtask

    // doors mostly stay as they are with the odd one flipping, now and then a noise byte
    task automatic run_segment(input int ticks, input int stall_at,
                               input int hold_door = -1, input int block_pct = 20);
        logic [doat_pkg::PORT_DOORS-1:0] doors;
        logic                            blocked;
        doors = $urandom_range(255);
        for (int k = 0; k < ticks; k++) begin
            if (k == stall_at)
                hold_cycles = STALL_CYCLES;
            if ($urandom_range(19) == 0) begin
                doors = $urandom_range(255);
            end else begin
                for (int n = 0; n < doat_pkg::PORT_DOORS; n++)
                    if ($urandom_range(9) == 0) doors[n] = ~doors[n];
            end
            if (hold_door >= 0)
                doors[hold_door] = 1'b1;
            blocked = ($urandom_range(99) < block_pct);
            send_tick(doors, blocked);
        end
        stop_ticks();
        drain();
    endtask

    // ------------------------------------------------------------------
    // directed part
    // ------------------------------------------------------------------
    bench_row_t directed_rows [$] = '{
        // nothing active after reset, every door is ignored
        '{ROW_TICK,  '0, 64'h0FF, 1'b1, '{8'h00, 8'h00, 1'b0}},
        // active count above the door count means all doors
        '{ROW_WRITE, doat_pkg::CFG_ACTIVE_DOORS,   64'd15, 1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_DISARMED_MASK,  64'd0,  1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_LAMP_DELAYS,    64'd0,  1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_CENTRAL_DELAYS, 64'd0,  1'b0, '0},
        // first opening: start is this tick, nothing fires yet
        '{ROW_TICK,  '0, 64'h0FF, 1'b1, '{8'h00, 8'h00, 1'b0}},
        // zero delays: lamp and first central alarm one tick later
        '{ROW_TICK,  '0, 64'h0FF, 1'b1, '{8'hFF, 8'hFF, 1'b1}},
        // repeat needs one more second
        '{ROW_TICK,  '0, 64'h0FF, 1'b1, '{8'hFF, 8'h00, 1'b1}},
        '{ROW_TICK,  '0, 64'h1FF, 1'b1, '{8'hFF, 8'h00, 1'b1}},
        // all closed clears flags and repeat counts
        '{ROW_TICK,  '0, 64'h000, 1'b1, '{8'h00, 8'h00, 1'b0}},
        // blocked central: lamp lights, alarm held back until unblocked
        '{ROW_TICK,  '0, 64'h155, 1'b1, '{8'h00, 8'h00, 1'b0}},
        '{ROW_TICK,  '0, 64'h155, 1'b1, '{8'h55, 8'h00, 1'b1}},
        '{ROW_TICK,  '0, 64'h055, 1'b1, '{8'h55, 8'h55, 1'b1}},
        '{ROW_TICK,  '0, 64'h055, 1'b1, '{8'h55, 8'h00, 1'b1}},
        // disarmed low doors keep their open state through a closed sensor
        '{ROW_WRITE, doat_pkg::CFG_DISARMED_MASK,  64'h0F, 1'b0, '0},
        '{ROW_TICK,  '0, 64'h000, 1'b1, '{8'h05, 8'h00, 1'b1}},
        '{ROW_TICK,  '0, 64'h0AA, 1'b1, '{8'h05, 8'h00, 1'b1}},
        '{ROW_TICK,  '0, 64'h0AA, 1'b1, '{8'hA5, 8'hA0, 1'b1}},
        // upper doors go inactive: bits low, state left alone
        '{ROW_WRITE, doat_pkg::CFG_ACTIVE_DOORS,   64'd4,  1'b0, '0},
        '{ROW_TICK,  '0, 64'h000, 1'b1, '{8'h05, 8'h00, 1'b1}},
        '{ROW_WRITE, doat_pkg::CFG_DISARMED_MASK,  64'd0,  1'b0, '0},
        '{ROW_TICK,  '0, 64'h000, 1'b1, '{8'h00, 8'h00, 1'b0}},
        // upper doors come back with their old open state, longest lamp delays
        '{ROW_WRITE, doat_pkg::CFG_ACTIVE_DOORS,   64'd8,  1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_LAMP_DELAYS,    '1,     1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_CENTRAL_DELAYS, 64'h0101_0101_0101_0101, 1'b0, '0},
        '{ROW_TICK,  '0, 64'h0FF, 1'b0, '0},
        '{ROW_TICK,  '0, 64'h17F, 1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_CENTRAL_DELAYS, '1,     1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_LAMP_DELAYS,    64'd0,  1'b0, '0},
        '{ROW_TICK,  '0, 64'h0F0, 1'b0, '0},
        // write to a missing register changes nothing
        '{ROW_WRITE, CFG_SPARE_INDEX,              '1,     1'b0, '0},
        '{ROW_TICK,  '0, 64'h0FF, 1'b0, '0},
        '{ROW_WRITE, doat_pkg::CFG_ACTIVE_DOORS,   64'd0,  1'b0, '0},
        '{ROW_TICK,  '0, 64'h0FF, 1'b1, '{8'h00, 8'h00, 1'b0}}
    };

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_door_open       = '0;
        s_central_blocked = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct   = 12;
        receiver_idle_pct = 78;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                stop_ticks();
                drain();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_tick(directed_rows[i].value[7:0], directed_rows[i].value[8],
                          directed_rows[i].pinned, directed_rows[i].report);
            end
        end
        stop_ticks();
        drain();

        // random part in three idling phases, a long receiver stall in each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 12;
                    receiver_idle_pct = 78;
                end
                1: begin
                    sender_idle_pct   = 78;
                    receiver_idle_pct = 12;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                shuffle_registers();
                run_segment(SEGMENT_TICKS, (seg == 2) ? 10 : -1);
            end
        end

        // soak: door zero held open with no central delay, first alarm then a quiet wait
        write_reg(doat_pkg::CFG_ACTIVE_DOORS, 64'(DOOR_LANES));
        write_reg(doat_pkg::CFG_DISARMED_MASK, '0);
        write_reg(doat_pkg::CFG_LAMP_DELAYS, '0);
        write_reg(doat_pkg::CFG_CENTRAL_DELAYS, {$urandom, $urandom_range(255) << 8});
        run_segment(SOAK_TICKS, -1, 0, 1);

        // last result beat is in, leave room for a stray one
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("door_open_alarm_timer_unit test passed");
        end else begin
            $display("door_open_alarm_timer_unit test failed");
        end
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("door_open_alarm_timer_unit test failed");
        $finish;
    end

endmodule
